// ----- sv/sha1_pkg.sv -----
`default_nettype none

package sha1_pkg;

    localparam int WordWidth  = 32;
    localparam int NumCv      = 5;
    localparam int NumW       = 16;
    localparam int NumRounds  = 80;
    localparam int LenWidth   = 61;

    localparam logic [WordWidth-1:0] IV [NumCv] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    localparam logic [WordWidth-1:0] K0 = 32'h5A82_7999;
    localparam logic [WordWidth-1:0] K1 = 32'h6ED9_EBA1;
    localparam logic [WordWidth-1:0] K2 = 32'h8F1B_BCDC;
    localparam logic [WordWidth-1:0] K3 = 32'hCA62_C1D6;

    localparam logic [WordWidth-1:0] PAD_MARKER = 32'h8000_0000;

    localparam logic [2:0] BYTES_PER_WORD = 3'd4;
    localparam logic [2:0] LAST_INDEX     = 3'd4;
    localparam logic [6:0] LAST_ROUND     = 7'd79;
    localparam logic [3:0] LEN_HI_SLOT    = 4'd14;
    localparam logic [3:0] LAST_SLOT      = 4'd15;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ROUND  = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_PAD    = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    function automatic logic [WordWidth-1:0] rotl(input logic [WordWidth-1:0] x,
                                                  input logic [4:0] n);
        logic [2*WordWidth-1:0] d;
        d = {x, x} << n;
        return d[2*WordWidth-1:WordWidth];
    endfunction

endpackage

`default_nettype wire

// ----- sv/sha1_message_digest_unit.sv -----
// SHA-1 digest engine. Message words enter on the s_axis side, first byte in
// bits 31:24, with the count of valid leading bytes in tuser and tlast on the
// last word. While idle, one word is taken per cycle. Each time sixteen
// words of a block are complete, the single round unit runs the 80 rounds
// and then the chaining update, with s_axis_tready low. After the last word
// the padding and length words are pushed one per cycle (held while a full
// block is compressed), one or two final blocks are compressed, and the five
// digest words leave on the m_axis side, index in tuser and tlast on the fifth.
`default_nettype none

module sha1_message_digest_unit
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // message_word
    input  wire logic [2:0]  s_axis_tuser,   // valid_bytes
    input  wire logic        s_axis_tlast,   // final_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // digest_word
    output logic [2:0]       m_axis_tuser,   // digest_index
    output logic             m_axis_tlast    // digest_last
);

    state_t                 state_reg, state_next;
    logic [WordWidth-1:0]   cv_reg [NumCv];
    logic [WordWidth-1:0]   wv_reg [NumCv];
    logic [WordWidth-1:0]   w_reg  [NumW];
    logic [WordWidth-1:0]   part_reg, part_next;
    logic [1:0]             off_reg, off_next;
    logic [3:0]             wcnt_reg;
    logic [LenWidth-1:0]    len_reg;
    logic [6:0]             round_reg;
    logic [2:0]             idx_reg;
    logic                   pad_reg, pad_next;
    logic                   marker_reg, marker_next;
    logic                   lenhi_reg, lenhi_next;

    logic                   in_fire, out_fire;
    logic [2:0]             nb;
    logic [WordWidth-1:0]   word_masked;
    logic [2*WordWidth-1:0] merge;
    logic [2:0]             total;
    logic                   push;
    logic [WordWidth-1:0]   push_word;
    logic                   block_full;
    logic [63:0]            bit_len;
    logic [WordWidth-1:0]   f, k, t, sched;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = cv_reg[idx_reg];
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == LAST_INDEX);

    assign nb          = (s_axis_tuser > BYTES_PER_WORD) ? BYTES_PER_WORD : s_axis_tuser;
    assign word_masked = s_axis_tdata & ~(32'hFFFF_FFFF >> {nb, 3'b000});
    assign merge       = {part_reg, 32'd0} | ({word_masked, 32'd0} >> {off_reg, 3'b000});
    assign total       = {1'b0, off_reg} + nb;
    assign bit_len     = {len_reg, 3'b000};
    assign block_full  = push && (wcnt_reg == LAST_SLOT);

    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f = wv_reg[3] ^ (wv_reg[1] & (wv_reg[2] ^ wv_reg[3]));
            k = K0;
        end
        else if (round_reg < 7'd40)
        begin
            f = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
            k = K1;
        end
        else if (round_reg < 7'd60)
        begin
            f = (wv_reg[1] & wv_reg[2]) | (wv_reg[3] & (wv_reg[1] | wv_reg[2]));
            k = K2;
        end
        else
        begin
            f = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
            k = K3;
        end
        t     = rotl(wv_reg[0], 5'd5) + f + wv_reg[4] + k + w_reg[0];
        sched = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 5'd1);
    end

    always_comb
    begin
        state_next  = state_reg;
        part_next   = part_reg;
        off_next    = off_reg;
        pad_next    = pad_reg;
        marker_next = marker_reg;
        lenhi_next  = lenhi_reg;
        push        = 1'b0;
        push_word   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    push      = total[2];
                    push_word = merge[63:32];
                    part_next = total[2] ? merge[31:0] : merge[63:32];
                    off_next  = total[1:0];
                    pad_next  = s_axis_tlast;
                    if (total[2] && (wcnt_reg == LAST_SLOT))
                        state_next = ST_ROUND;
                    else if (s_axis_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!pad_reg)
                    state_next = ST_IDLE;
                else if (lenhi_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                push = 1'b1;
                if (!marker_reg)
                begin
                    push_word   = part_reg | (PAD_MARKER >> {off_reg, 3'b000});
                    part_next   = '0;
                    off_next    = 2'd0;
                    marker_next = 1'b1;
                end
                else if (lenhi_reg && (wcnt_reg == LAST_SLOT))
                    push_word = bit_len[31:0];
                else if (wcnt_reg == LEN_HI_SLOT)
                begin
                    push_word  = bit_len[63:32];
                    lenhi_next = 1'b1;
                end
                if (wcnt_reg == LAST_SLOT)
                    state_next = ST_ROUND;
            end
            ST_OUT:
            begin
                if (out_fire && (idx_reg == LAST_INDEX))
                begin
                    state_next  = ST_IDLE;
                    part_next   = '0;
                    off_next    = 2'd0;
                    pad_next    = 1'b0;
                    marker_next = 1'b0;
                    lenhi_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            part_reg   <= '0;
            off_reg    <= 2'd0;
            wcnt_reg   <= 4'd0;
            len_reg    <= '0;
            round_reg  <= 7'd0;
            idx_reg    <= 3'd0;
            pad_reg    <= 1'b0;
            marker_reg <= 1'b0;
            lenhi_reg  <= 1'b0;
            for (int i = 0; i < NumCv; i++)
                cv_reg[i] <= IV[i];
        end
        else
        begin
            state_reg  <= state_next;
            part_reg   <= part_next;
            off_reg    <= off_next;
            pad_reg    <= pad_next;
            marker_reg <= marker_next;
            lenhi_reg  <= lenhi_next;
            if (in_fire)
                len_reg <= len_reg + LenWidth'(nb);
            if (push)
                wcnt_reg <= wcnt_reg + 4'd1;
            if (state_reg == ST_ROUND)
                round_reg <= (round_reg == LAST_ROUND) ? 7'd0 : round_reg + 7'd1;
            if (state_reg == ST_UPDATE)
            begin
                for (int i = 0; i < NumCv; i++)
                    cv_reg[i] <= cv_reg[i] + wv_reg[i];
            end
            if (out_fire)
            begin
                if (idx_reg == LAST_INDEX)
                begin
                    idx_reg  <= 3'd0;
                    len_reg  <= '0;
                    wcnt_reg <= 4'd0;
                    for (int i = 0; i < NumCv; i++)
                        cv_reg[i] <= IV[i];
                end
                else
                    idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push || (state_reg == ST_ROUND))
        begin
            for (int i = 0; i < NumW - 1; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[NumW - 1] <= push ? push_word : sched;
        end
        if (block_full)
        begin
            for (int i = 0; i < NumCv; i++)
                wv_reg[i] <= cv_reg[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            wv_reg[0] <= t;
            wv_reg[1] <= wv_reg[0];
            wv_reg[2] <= rotl(wv_reg[1], 5'd30);
            wv_reg[3] <= wv_reg[2];
            wv_reg[4] <= wv_reg[3];
        end
    end

endmodule

`default_nettype wire

// ----- sv/sha1_chk.sv -----
`default_nettype none

module sha1_chk
    import sha1_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("digest word changed while stalled");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while digest pending");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == LAST_INDEX)))
        else $error("tlast does not match digest index");

    a_end_digest: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("digest continued past its last word");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !m_axis_tvalid)
        else $error("digest after a non-final word");

endmodule

bind sha1_message_digest_unit sha1_chk u_sha1_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
